@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cond never holds.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

@@ rtl/core/sha1_pkg.sv @@
// Types, constants and sequencer codes of the SHA-1 digest unit.
// No dependencies.
package sha1_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 5;
  localparam int unsigned WinDepth = 16;
  localparam int unsigned CountW   = 61;

  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [6:0] Phase1End = 7'd20;
  localparam logic [6:0] Phase2End = 7'd40;
  localparam logic [6:0] Phase3End = 7'd60;
  localparam logic [2:0] LastWord  = 3'd4;
  localparam logic [5:0] LastPos   = 6'd63;
  localparam logic [5:0] LenPos    = 6'd56;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]       PadByte = 8'h80;

  localparam logic [WordW-1:0] HInit [NumWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_message;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1_out_t;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
    logic [WordW-1:0] e;
  } sha1_work_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROUND = 6'b000010,
    S_FINAL = 6'b000100,
    S_PAD   = 6'b001000,
    S_LEN   = 6'b010000,
    S_OUT   = 6'b100000
  } sha1_state_e;

endpackage

@@ rtl/core/sha1_round.sv @@
// One SHA-1 round: select function and constant, add, rotate the working words.
// Depends on sha1_pkg.
module sha1_round (
  input  logic [6:0]          round_i,
  input  sha1_pkg::sha1_work_t work_i,
  input  logic [31:0]         w_i,
  output sha1_pkg::sha1_work_t work_o
);
  import sha1_pkg::*;

  logic [WordW-1:0] f;
  logic [WordW-1:0] k;
  logic [WordW-1:0] tmp;

  always_comb begin
    if (round_i < Phase1End) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = K0;
    end else if (round_i < Phase2End) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K1;
    end else if (round_i < Phase3End) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K3;
    end
    tmp = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + k + w_i;
    work_o.a = tmp;
    work_o.b = work_i.a;
    work_o.c = {work_i.b[1:0], work_i.b[31:2]};
    work_o.d = work_i.c;
    work_o.e = work_i.d;
  end

endmodule

@@ rtl/core/sha1_message_digest_unit.sv @@
// SHA-1 digest unit: byte packing, padding, 80-round sequencer, digest output.
// Depends on sha1_pkg and sha1_round.
// A byte beat is taken only while idle; the beat that fills a block starts 80 rounds
// on the shared round unit and a chain update. An end beat starts padding and compression,
// with a second block when the tail leaves no room for the length, then 5 output beats.
// Reset loads the initial chain, clears the byte count and returns the sequencer to idle.
module sha1_message_digest_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sha1_pkg::sha1_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sha1_pkg::sha1_out_t out_data_o
);
  import sha1_pkg::*;

  sha1_state_e      state_q, state_d;
  logic [WordW-1:0] window_q [WinDepth];
  logic [WordW-1:0] window_d [WinDepth];
  logic [WordW-1:0] chain_q [NumWords];
  logic [WordW-1:0] chain_d [NumWords];
  sha1_work_t       work_q, work_d, work_next;
  logic [CountW-1:0] count_q, count_d;
  logic [6:0]       round_q, round_d;
  logic [2:0]       idx_q, idx_d;
  logic             ending_q, ending_d;
  logic             padded_q, padded_d;
  logic             len_done_q, len_done_d;

  logic [5:0]       pos;
  logic [3:0]       wi;
  logic [WordW-1:0] byte_word;
  logic [WordW-1:0] pad_word;
  logic [63:0]      bit_len;
  logic [WordW-1:0] sched_w;

  sha1_round u_round (
    .round_i (round_q),
    .work_i  (work_q),
    .w_i     (window_q[0]),
    .work_o  (work_next)
  );

  assign pos       = count_q[5:0];
  assign wi        = pos[5:2];
  assign byte_word = {in_data_i.data_byte, 24'd0} >> {pos[1:0], 3'd0};
  assign pad_word  = {PadByte, 24'd0} >> {pos[1:0], 3'd0};
  assign bit_len   = {count_q, 3'd0};
  assign sched_w   = window_q[13] ^ window_q[8] ^ window_q[2] ^ window_q[0];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o.digest_word = chain_q[idx_q];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == LastWord);

  always_comb begin
    state_d    = state_q;
    window_d   = window_q;
    chain_d    = chain_q;
    work_d     = work_q;
    count_d    = count_q;
    round_d    = round_q;
    idx_d      = idx_q;
    ending_d   = ending_q;
    padded_d   = padded_q;
    len_done_d = len_done_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.has_byte) begin
            window_d[wi] = ((pos[1:0] == 2'd0) ? '0 : window_q[wi]) | byte_word;
            count_d      = count_q + CountW'(1);
          end
          if (in_data_i.has_byte && (pos == LastPos)) begin
            state_d  = S_ROUND;
            work_d   = {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
            round_d  = '0;
            ending_d = in_data_i.end_of_message;
          end else if (in_data_i.end_of_message) begin
            state_d  = S_PAD;
            ending_d = 1'b1;
          end
        end
      end
      S_ROUND: begin
        for (int i = 0; i < WinDepth - 1; i++) begin
          window_d[i] = window_q[i+1];
        end
        window_d[WinDepth-1] = {sched_w[30:0], sched_w[31]};
        work_d = work_next;
        if (round_q == LastRound) begin
          state_d = S_FINAL;
          round_d = '0;
        end else begin
          round_d = round_q + 7'd1;
        end
      end
      S_FINAL: begin
        chain_d[0] = chain_q[0] + work_q.a;
        chain_d[1] = chain_q[1] + work_q.b;
        chain_d[2] = chain_q[2] + work_q.c;
        chain_d[3] = chain_q[3] + work_q.d;
        chain_d[4] = chain_q[4] + work_q.e;
        if (!ending_q) begin
          state_d = S_IDLE;
        end else if (!padded_q) begin
          state_d = S_PAD;
        end else if (!len_done_q) begin
          state_d = S_LEN;
        end else begin
          state_d = S_OUT;
          idx_d   = '0;
        end
      end
      S_PAD: begin
        for (int i = 0; i < WinDepth; i++) begin
          if (4'(i) > wi) begin
            window_d[i] = '0;
          end
        end
        window_d[wi] = ((pos[1:0] == 2'd0) ? '0 : window_q[wi]) | pad_word;
        if (pos < LenPos) begin
          window_d[WinDepth-2] = bit_len[63:32];
          window_d[WinDepth-1] = bit_len[31:0];
          len_done_d = 1'b1;
        end
        padded_d = 1'b1;
        state_d  = S_ROUND;
        work_d   = {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
        round_d  = '0;
      end
      S_LEN: begin
        for (int i = 0; i < WinDepth; i++) begin
          window_d[i] = '0;
        end
        window_d[WinDepth-2] = bit_len[63:32];
        window_d[WinDepth-1] = bit_len[31:0];
        len_done_d = 1'b1;
        state_d    = S_ROUND;
        work_d     = {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
        round_d    = '0;
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (idx_q == LastWord) begin
            chain_d    = HInit;
            count_d    = '0;
            idx_d      = '0;
            ending_d   = 1'b0;
            padded_d   = 1'b0;
            len_done_d = 1'b0;
            state_d    = S_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      chain_q    <= HInit;
      work_q     <= '0;
      count_q    <= '0;
      round_q    <= '0;
      idx_q      <= '0;
      ending_q   <= 1'b0;
      padded_q   <= 1'b0;
      len_done_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      chain_q    <= chain_d;
      work_q     <= work_d;
      count_q    <= count_d;
      round_q    <= round_d;
      idx_q      <= idx_d;
      ending_q   <= ending_d;
      padded_q   <= padded_d;
      len_done_q <= len_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
  end

endmodule

@@ rtl/core/sha1_checker.sv @@
// Port-level checks of the SHA-1 digest unit, bound to the top level.
// Depends on sha1_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sha1_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input sha1_pkg::sha1_out_t out_data_o
);
  import sha1_pkg::*;

  `ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o, "ready during output")
  `ASSERT_CLK(a_last_flag, clk_i, rst_ni, out_valid_o |-> ((out_data_o.word_index <= LastWord) && (out_data_o.last_word == (out_data_o.word_index == LastWord))), "bad word index")
  `ASSERT_CLK(a_next_word, clk_i, rst_ni, (out_valid_o && out_ready_i && !out_data_o.last_word) |=> (out_valid_o && (out_data_o.word_index == $past(out_data_o.word_index) + 3'd1)), "digest word skipped")
  `ASSERT_CLK(a_back_idle, clk_i, rst_ni, (out_valid_o && out_ready_i && out_data_o.last_word) |=> (in_ready_o && !out_valid_o), "not idle after digest")

endmodule

bind sha1_message_digest_unit sha1_checker u_sha1_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
